// ===== rtl/tpr_pkg.sv =====
package tpr_pkg;

    localparam logic [31:0] LOCAL_ISN      = 32'h1000_0000;
    localparam int unsigned HDR_BYTES      = 20;
    localparam int unsigned FRAME_OVERHEAD = 54;
    localparam int unsigned FRAME_LIMIT    = 1600;
    localparam int unsigned SEND_MAX_LEN   = FRAME_LIMIT - FRAME_OVERHEAD;

    localparam int unsigned FL_FIN = 0;
    localparam int unsigned FL_SYN = 1;
    localparam int unsigned FL_RST = 2;
    localparam int unsigned FL_ACK = 4;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_SYNACK = 2'd2,
        KIND_DATA   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_OPEN  = 2'd1,
        EV_CLOSE = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        CLS_DROP,
        CLS_SEND,
        CLS_RST,
        CLS_SYN,
        CLS_SEG
    } cls_kind_t;

    // One classified item, everything the back end needs that does not
    // depend on connection state.
    typedef struct packed {
        cls_kind_t   cls;
        logic [15:0] sport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic        ack_flag;
        logic        fin;
        logic        hdr_bad;
        logic        plen_zero;
        logic [5:0]  hlen;
        logic [15:0] plen;
        logic [15:0] len;
        logic        send_ok;
        logic [32:0] end_seq;
        logic [31:0] end_fin;
        logic [31:0] seq_p1;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
    } cls_t;

endpackage

// ===== rtl/tpr_seg_if.sv =====
interface tpr_seg_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] sender_port;
    logic [15:0] target_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [3:0]  data_offset_words;
    logic [15:0] seg_len;
    logic [31:0] src_ip;
    logic [47:0] src_mac;

    modport source (
        output valid, op, sender_port, target_port, seq, ack, flags,
               data_offset_words, seg_len, src_ip, src_mac,
        input  ready
    );
    modport sink (
        input  valid, op, sender_port, target_port, seq, ack, flags,
               data_offset_words, seg_len, src_ip, src_mac,
        output ready
    );
endinterface

// ===== rtl/tpr_reply_if.sv =====
interface tpr_reply_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reply_kind;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic [15:0] reply_peer_port;
    logic [31:0] reply_dst_ip;
    logic [47:0] reply_dst_mac;
    logic [15:0] deliver_start;
    logic [15:0] deliver_len;
    logic [1:0]  event_res;
    logic        established;
    logic        connected;

    modport source (
        output valid, reply_kind, reply_seq, reply_ack, reply_peer_port,
               reply_dst_ip, reply_dst_mac, deliver_start, deliver_len,
               event_res, established, connected,
        input  ready
    );
    modport sink (
        input  valid, reply_kind, reply_seq, reply_ack, reply_peer_port,
               reply_dst_ip, reply_dst_mac, deliver_start, deliver_len,
               event_res, established, connected,
        output ready
    );
endinterface

// ===== rtl/tpr_front.sv =====
module tpr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [15:0]     cfg_wr_data,
    tpr_seg_if.sink         seg_in,
    output tpr_pkg::cls_t   cls,
    output logic            cls_valid,
    input  logic            cls_ready
);

    logic [15:0] listen_port_reg;
    logic [5:0]  hlen;
    logic [15:0] plen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_port_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            listen_port_reg <= cfg_wr_data;
        end
    end

    assign seg_in.ready = cls_ready;
    assign cls_valid    = seg_in.valid;

    assign hlen = {seg_in.data_offset_words, 2'b00};
    assign plen = seg_in.seg_len - {10'd0, hlen};

    always_comb
    begin
        cls.sport     = seg_in.sender_port;
        cls.seq       = seg_in.seq;
        cls.ack       = seg_in.ack;
        cls.ack_flag  = seg_in.flags[tpr_pkg::FL_ACK];
        cls.fin       = seg_in.flags[tpr_pkg::FL_FIN];
        cls.hdr_bad   = (hlen < 6'(tpr_pkg::HDR_BYTES)) || ({10'd0, hlen} > seg_in.seg_len);
        cls.plen_zero = (plen == 16'd0);
        cls.hlen      = hlen;
        cls.plen      = plen;
        cls.len       = seg_in.seg_len;
        cls.send_ok   = (seg_in.seg_len <= 16'(tpr_pkg::SEND_MAX_LEN));
        // Segment end; the in-order case takes this as the new peer sequence.
        cls.end_seq   = {1'b0, seg_in.seq} + {17'd0, plen};
        cls.end_fin   = seg_in.seq + {16'd0, plen} + 32'd1;
        cls.seq_p1    = seg_in.seq + 32'd1;
        cls.src_ip    = seg_in.src_ip;
        cls.src_mac   = seg_in.src_mac;

        if (seg_in.op)
        begin
            cls.cls = tpr_pkg::CLS_SEND;
        end
        else if (seg_in.seg_len < 16'(tpr_pkg::HDR_BYTES) ||
                 seg_in.target_port != listen_port_reg)
        begin
            cls.cls = tpr_pkg::CLS_DROP;
        end
        else if (seg_in.flags[tpr_pkg::FL_RST])
        begin
            cls.cls = tpr_pkg::CLS_RST;
        end
        else if (seg_in.flags[tpr_pkg::FL_SYN] && !seg_in.flags[tpr_pkg::FL_ACK])
        begin
            cls.cls = tpr_pkg::CLS_SYN;
        end
        else
        begin
            cls.cls = tpr_pkg::CLS_SEG;
        end
    end

endmodule

// ===== rtl/tpr_fifo.sv =====
module tpr_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  tpr_pkg::cls_t   wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output tpr_pkg::cls_t   rd_data,
    output logic            rd_valid,
    input  logic            rd_pop
);

    tpr_pkg::cls_t                    entry_reg [tpr_pkg::FIFO_DEPTH];
    logic [tpr_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [tpr_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [tpr_pkg::FIFO_CNT_W-1:0]   count_reg;
    logic                             push;
    logic                             pop;

    assign wr_ready = (count_reg != tpr_pkg::FIFO_CNT_W'(tpr_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == tpr_pkg::FIFO_PTR_W'(tpr_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == tpr_pkg::FIFO_PTR_W'(tpr_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tpr_back.sv =====
module tpr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tpr_pkg::cls_t   head,
    input  logic            head_valid,
    output logic            head_pop,
    tpr_reply_if.source     reply_out
);

    // Connection state
    logic        active_reg,     active_next;
    logic        est_reg,        est_next;
    logic [15:0] peer_port_reg,  peer_port_next;
    logic [31:0] peer_ip_reg,    peer_ip_next;
    logic [47:0] peer_mac_reg,   peer_mac_next;
    logic [31:0] peer_seq_reg,   peer_seq_next;
    logic [31:0] local_seq_reg,  local_seq_next;

    // Result register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_seq_reg;
    logic [31:0] out_ack_reg;
    logic [15:0] out_port_reg;
    logic [31:0] out_ip_reg;
    logic [47:0] out_mac_reg;
    logic [15:0] out_dstart_reg;
    logic [15:0] out_dlen_reg;
    logic [1:0]  out_event_reg;
    logic        out_est_reg;
    logic        out_active_reg;

    tpr_pkg::kind_t  kind;
    tpr_pkg::event_t ev;
    logic [31:0]     rs;
    logic [31:0]     ra;
    logic [15:0]     dstart;
    logic [15:0]     dlen;
    logic [15:0]     seen;
    logic            seq_below;
    logic            seq_above;
    logic            all_seen;

    assign head_pop = head_valid && (!out_valid_reg || reply_out.ready);

    assign seq_below = head.seq < peer_seq_reg;
    assign seq_above = head.seq > peer_seq_reg;
    assign all_seen  = head.end_seq <= {1'b0, peer_seq_reg};
    // Bytes already taken; below the payload length wherever it is used.
    assign seen      = peer_seq_reg[15:0] - head.seq[15:0];

    always_comb
    begin
        active_next    = active_reg;
        est_next       = est_reg;
        peer_port_next = peer_port_reg;
        peer_ip_next   = peer_ip_reg;
        peer_mac_next  = peer_mac_reg;
        peer_seq_next  = peer_seq_reg;
        local_seq_next = local_seq_reg;
        kind           = tpr_pkg::KIND_NONE;
        ev             = tpr_pkg::EV_NONE;
        rs             = '0;
        ra             = '0;
        dstart         = '0;
        dlen           = '0;

        case (head.cls)
            tpr_pkg::CLS_SEND:
            begin
                if (head.send_ok)
                begin
                    kind = tpr_pkg::KIND_DATA;
                    rs   = local_seq_reg;
                    ra   = peer_seq_reg;
                end
                local_seq_next = local_seq_reg + {16'd0, head.len};
            end
            tpr_pkg::CLS_RST:
            begin
                active_next = 1'b0;
                est_next    = 1'b0;
                ev          = tpr_pkg::EV_CLOSE;
            end
            tpr_pkg::CLS_SYN:
            begin
                peer_ip_next   = head.src_ip;
                peer_mac_next  = head.src_mac;
                peer_port_next = head.sport;
                peer_seq_next  = head.seq_p1;
                local_seq_next = tpr_pkg::LOCAL_ISN + 32'd1;
                active_next    = 1'b1;
                est_next       = 1'b0;
                ev             = tpr_pkg::EV_OPEN;
                kind           = tpr_pkg::KIND_SYNACK;
                rs             = tpr_pkg::LOCAL_ISN;
                ra             = head.seq_p1;
            end
            tpr_pkg::CLS_SEG:
            begin
                if (active_reg && head.sport == peer_port_reg)
                begin
                    if (head.ack_flag && head.ack == local_seq_reg)
                    begin
                        est_next = 1'b1;
                    end
                    if (head.hdr_bad)
                    begin
                        kind = tpr_pkg::KIND_ACK;
                    end
                    else if (head.plen_zero)
                    begin
                        if (head.fin && head.seq == peer_seq_reg)
                        begin
                            peer_seq_next = peer_seq_reg + 32'd1;
                            kind          = tpr_pkg::KIND_ACK;
                            active_next   = 1'b0;
                            est_next      = 1'b0;
                            ev            = tpr_pkg::EV_CLOSE;
                        end
                    end
                    else if ((seq_below && all_seen) || seq_above)
                    begin
                        kind = tpr_pkg::KIND_ACK;
                    end
                    else
                    begin
                        // Trim the retransmitted head; the new end is the segment end, one past it on FIN.
                        dstart = {10'd0, head.hlen} + seen;
                        dlen   = head.plen - seen;
                        kind   = tpr_pkg::KIND_ACK;
                        if (head.fin)
                        begin
                            peer_seq_next = head.end_fin;
                            active_next   = 1'b0;
                            est_next      = 1'b0;
                            ev            = tpr_pkg::EV_CLOSE;
                        end
                        else
                        begin
                            peer_seq_next = head.end_seq[31:0];
                        end
                    end
                    if (kind == tpr_pkg::KIND_ACK)
                    begin
                        rs = local_seq_reg;
                        ra = peer_seq_next;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            est_reg       <= 1'b0;
            peer_port_reg <= '0;
            peer_ip_reg   <= '0;
            peer_mac_reg  <= '0;
            peer_seq_reg  <= '0;
            local_seq_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (head_pop)
            begin
                active_reg    <= active_next;
                est_reg       <= est_next;
                peer_port_reg <= peer_port_next;
                peer_ip_reg   <= peer_ip_next;
                peer_mac_reg  <= peer_mac_next;
                peer_seq_reg  <= peer_seq_next;
                local_seq_reg <= local_seq_next;
                out_valid_reg <= 1'b1;
            end
            else if (reply_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            out_kind_reg   <= kind;
            out_seq_reg    <= rs;
            out_ack_reg    <= ra;
            out_port_reg   <= (kind == tpr_pkg::KIND_NONE) ? '0 : peer_port_next;
            out_ip_reg     <= (kind == tpr_pkg::KIND_NONE) ? '0 : peer_ip_next;
            out_mac_reg    <= (kind == tpr_pkg::KIND_NONE) ? '0 : peer_mac_next;
            out_dstart_reg <= dstart;
            out_dlen_reg   <= dlen;
            out_event_reg  <= ev;
            out_est_reg    <= est_next;
            out_active_reg <= active_next;
        end
    end

    assign reply_out.valid           = out_valid_reg;
    assign reply_out.reply_kind      = out_kind_reg;
    assign reply_out.reply_seq       = out_seq_reg;
    assign reply_out.reply_ack       = out_ack_reg;
    assign reply_out.reply_peer_port = out_port_reg;
    assign reply_out.reply_dst_ip    = out_ip_reg;
    assign reply_out.reply_dst_mac   = out_mac_reg;
    assign reply_out.deliver_start   = out_dstart_reg;
    assign reply_out.deliver_len     = out_dlen_reg;
    assign reply_out.event_res       = out_event_reg;
    assign reply_out.established     = out_est_reg;
    assign reply_out.connected       = out_active_reg;

endmodule

// ===== rtl/tcp_passive_receive_fsm_top.sv =====
// Channel     | Dir | Handshake     | Carries
// seg_in      | in  | valid / ready | received header (op 0) or bytes sent note (op 1)
// reply_out   | out | valid / ready | reply kind, numbers, peer, delivery, event, flags
// cfg_wr_*    | in  | write enable  | listen_port, no read-back
//
// One item per cycle sustained while reply_out is not stalled; a result is
// registered after its transfer on seg_in (queue write, then the back end's
// decide-and-register step). The rate is set by the back end, which decides and
// updates the connection state for each item as it pops it from the queue.
// rst_n clears the connection state, listen_port, the queue and the result valid.
// A stall on reply_out holds the result register; the two-entry queue absorbs
// items already in flight and seg_in.ready drops only when the queue is full.
module tcp_passive_receive_fsm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    tpr_seg_if.sink     seg_in,
    tpr_reply_if.source reply_out
);

    tpr_pkg::cls_t front_cls;
    logic          front_valid;
    logic          front_ready;
    tpr_pkg::cls_t head_cls;
    logic          head_valid;
    logic          head_pop;

    // Front: accept the transfer, hold listen_port, classify without state.
    tpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seg_in      (seg_in),
        .cls         (front_cls),
        .cls_valid   (front_valid),
        .cls_ready   (front_ready)
    );

    // Short queue decoupling classification from execution.
    tpr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_cls),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (head_cls),
        .rd_valid (head_valid),
        .rd_pop   (head_pop)
    );

    // Back: apply the item to the connection state and register the reply.
    tpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cls),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .reply_out  (reply_out)
    );

endmodule

// ===== test/tpr_reply_checker.sv =====
module tpr_reply_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    tpr_seg_if          seg_mon,
    tpr_reply_if        reply_mon,
    output int          pending,
    output int          fail_count
);

    typedef struct {
        tpr_pkg::kind_t  kind;
        logic [31:0]     seq;
        logic [31:0]     ack;
        logic [15:0]     port;
        logic [31:0]     ip;
        logic [47:0]     mac;
        logic [15:0]     dstart;
        logic [15:0]     dlen;
        tpr_pkg::event_t ev;
        logic            est;
        logic            conn;
    } reply_t;

    // Connection state as this checker tracks it.
    logic [15:0] listen_port;
    logic        conn_up;
    logic        conn_estab;
    logic [15:0] peer_port_r;
    logic [31:0] peer_ip_r;
    logic [47:0] peer_mac_r;
    logic [31:0] rcv_next;
    logic [31:0] snd_next;

    reply_t pending_replies[$];
    reply_t exp_r;
    reply_t new_r;
    string  note;
    int     replies_seen = 0;
    int     queued = 0;
    int     errors = 0;

    assign pending    = queued;
    assign fail_count = errors;

    task automatic report_mismatch(input string what);
        if (errors < 100)
            $display("ERROR reply %0d:%s", replies_seen, what);
        errors++;
    endtask

    function automatic string diff_note(string name, logic [47:0] got, logic [47:0] want);
        if (got === want)
            return "";
        return $sformatf(" %s got %0h exp %0h", name, got, want);
    endfunction

    // Decide the reply for the item on seg_mon and advance the connection state.
    task automatic decide_reply(output reply_t r);
        logic [31:0] len;
        logic [31:0] hlen;
        logic [31:0] plen;
        logic [31:0] start;
        logic        fin;
        r.kind   = tpr_pkg::KIND_NONE;
        r.seq    = '0;
        r.ack    = '0;
        r.port   = '0;
        r.ip     = '0;
        r.mac    = '0;
        r.dstart = '0;
        r.dlen   = '0;
        r.ev     = tpr_pkg::EV_NONE;
        len  = 32'(seg_mon.seg_len);
        hlen = 32'(seg_mon.data_offset_words) * 4;
        if (seg_mon.op)
        begin
            if (len <= tpr_pkg::SEND_MAX_LEN)
            begin
                r.kind = tpr_pkg::KIND_DATA;
                r.seq  = snd_next;
                r.ack  = rcv_next;
            end
            // advance even when the frame is too big to go out
            snd_next = snd_next + len;
        end
        else if (len >= tpr_pkg::HDR_BYTES && seg_mon.target_port == listen_port)
        begin
            if (seg_mon.flags[tpr_pkg::FL_RST])
            begin
                conn_up    = 1'b0;
                conn_estab = 1'b0;
                r.ev       = tpr_pkg::EV_CLOSE;
            end
            else if (seg_mon.flags[tpr_pkg::FL_SYN] && !seg_mon.flags[tpr_pkg::FL_ACK])
            begin
                peer_ip_r   = seg_mon.src_ip;
                peer_mac_r  = seg_mon.src_mac;
                peer_port_r = seg_mon.sender_port;
                rcv_next    = seg_mon.seq + 32'd1;
                conn_up     = 1'b1;
                conn_estab  = 1'b0;
                r.ev        = tpr_pkg::EV_OPEN;
                r.kind      = tpr_pkg::KIND_SYNACK;
                r.seq       = tpr_pkg::LOCAL_ISN;
                r.ack       = rcv_next;
                snd_next    = tpr_pkg::LOCAL_ISN + 32'd1;
            end
            else if (conn_up && seg_mon.sender_port == peer_port_r)
            begin
                if (seg_mon.flags[tpr_pkg::FL_ACK] && seg_mon.ack == snd_next)
                    conn_estab = 1'b1;
                if (hlen < tpr_pkg::HDR_BYTES || hlen > len)
                    r.kind = tpr_pkg::KIND_ACK;
                else
                begin
                    plen  = len - hlen;
                    start = hlen;
                    fin   = seg_mon.flags[tpr_pkg::FL_FIN];
                    if (plen == 0)
                    begin
                        if (fin && seg_mon.seq == rcv_next)
                        begin
                            rcv_next   = rcv_next + 32'd1;
                            r.kind     = tpr_pkg::KIND_ACK;
                            conn_up    = 1'b0;
                            conn_estab = 1'b0;
                            r.ev       = tpr_pkg::EV_CLOSE;
                        end
                    end
                    else if (seg_mon.seq < rcv_next && rcv_next - seg_mon.seq >= plen)
                        r.kind = tpr_pkg::KIND_ACK;
                    else if (seg_mon.seq > rcv_next)
                        r.kind = tpr_pkg::KIND_ACK;
                    else
                    begin
                        // trim the bytes already seen
                        if (seg_mon.seq < rcv_next)
                        begin
                            start = start + (rcv_next - seg_mon.seq);
                            plen  = plen - (rcv_next - seg_mon.seq);
                        end
                        rcv_next = rcv_next + plen;
                        r.dstart = start[15:0];
                        r.dlen   = plen[15:0];
                        r.kind   = tpr_pkg::KIND_ACK;
                        if (fin)
                        begin
                            rcv_next   = rcv_next + 32'd1;
                            conn_up    = 1'b0;
                            conn_estab = 1'b0;
                            r.ev       = tpr_pkg::EV_CLOSE;
                        end
                    end
                end
                if (r.kind == tpr_pkg::KIND_ACK)
                begin
                    r.seq = snd_next;
                    r.ack = rcv_next;
                end
            end
        end
        if (r.kind != tpr_pkg::KIND_NONE)
        begin
            r.port = peer_port_r;
            r.ip   = peer_ip_r;
            r.mac  = peer_mac_r;
        end
        r.est  = conn_estab;
        r.conn = conn_up;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_port = '0;
            conn_up     = 1'b0;
            conn_estab  = 1'b0;
            peer_port_r = '0;
            peer_ip_r   = '0;
            peer_mac_r  = '0;
            rcv_next    = '0;
            snd_next    = '0;
            pending_replies.delete();
            queued <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                listen_port = cfg_wr_data;
            // check the result leaving first: it always belongs to an older item
            if (reply_mon.valid && reply_mon.ready)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch(" result with nothing expected");
                else
                begin
                    exp_r = pending_replies.pop_front();
                    note = {diff_note("kind", reply_mon.reply_kind, exp_r.kind),
                            diff_note("seq", reply_mon.reply_seq, exp_r.seq),
                            diff_note("ack", reply_mon.reply_ack, exp_r.ack),
                            diff_note("port", reply_mon.reply_peer_port, exp_r.port),
                            diff_note("ip", reply_mon.reply_dst_ip, exp_r.ip),
                            diff_note("mac", reply_mon.reply_dst_mac, exp_r.mac),
                            diff_note("dstart", reply_mon.deliver_start, exp_r.dstart),
                            diff_note("dlen", reply_mon.deliver_len, exp_r.dlen),
                            diff_note("event", reply_mon.event_res, exp_r.ev),
                            diff_note("estab", reply_mon.established, exp_r.est),
                            diff_note("conn", reply_mon.connected, exp_r.conn)};
                    if (note != "")
                        report_mismatch(note);
                end
                replies_seen++;
            end
            if (seg_mon.valid && seg_mon.ready)
            begin
                decide_reply(new_r);
                pending_replies.push_back(new_r);
            end
            queued <= pending_replies.size();
        end
    end

endmodule

// ===== test/tb_tcp_passive_receive_fsm_top.sv =====
module tb_tcp_passive_receive_fsm_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASES       = 4;

    // Flag masks; all but F_PSH are built from the bit positions of the package.
    localparam logic [7:0] F_FIN = 8'(1 << tpr_pkg::FL_FIN);
    localparam logic [7:0] F_SYN = 8'(1 << tpr_pkg::FL_SYN);
    localparam logic [7:0] F_RST = 8'(1 << tpr_pkg::FL_RST);
    localparam logic [7:0] F_ACK = 8'(1 << tpr_pkg::FL_ACK);
    localparam logic [7:0] F_PSH = 8'h08;

    typedef struct {
        logic        op;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [3:0]  doff;
        logic [15:0] len;
        logic [31:0] ip;
        logic [47:0] mac;
    } seg_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          pending;
    int          fail_count;
    int          cycle_count = 0;

    // Stimulus knobs: percent of cycles the sender idles and the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;

    // The generator's own view of the connection; it only steers the
    // stimulus toward deep states, the checker decides what is correct.
    logic [15:0] listen;
    logic [15:0] peer_sport;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic [31:0] gen_peer_seq;
    logic [31:0] gen_local_seq;

    tpr_seg_if   seg_bus();
    tpr_reply_if reply_bus();

    tcp_passive_receive_fsm_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seg_in      (seg_bus),
        .reply_out   (reply_bus)
    );

    tpr_reply_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seg_mon     (seg_bus),
        .reply_mon   (reply_bus),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the reply channel at random; stall_pct follows the phase.
    initial
    begin
        reply_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            reply_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Guard against a hung run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Present one item and hold it until the transfer. Valid stays high when
    // the next item follows without a gap, so it is never dropped and raised
    // in the same step.
    task automatic send_item(input seg_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            seg_bus.valid <= 1'b0;
            @(posedge clk);
        end
        seg_bus.valid             <= 1'b1;
        seg_bus.op                <= it.op;
        seg_bus.sender_port       <= it.sport;
        seg_bus.target_port       <= it.dport;
        seg_bus.seq               <= it.seq;
        seg_bus.ack               <= it.ack;
        seg_bus.flags             <= it.flags;
        seg_bus.data_offset_words <= it.doff;
        seg_bus.seg_len           <= it.len;
        seg_bus.src_ip            <= it.ip;
        seg_bus.src_mac           <= it.mac;
        @(posedge clk);
        while (!seg_bus.ready)
            @(posedge clk);
        sent++;
    endtask

    // Fully random item, aimed at the listen port most of the time.
    function automatic seg_item_t noise_item();
        seg_item_t it;
        it.op    = ($urandom_range(4) == 0);
        it.sport = ($urandom_range(3) == 0) ? peer_sport : 16'($urandom);
        it.dport = ($urandom_range(3) != 0) ? listen : 16'($urandom);
        it.seq   = $urandom;
        it.ack   = $urandom;
        it.flags = 8'($urandom);
        it.doff  = 4'($urandom);
        it.len   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(140));
        it.ip    = $urandom;
        it.mac   = {16'($urandom), 32'($urandom)};
        return it;
    endfunction

    // Segment from the current peer to the listen port, acking our next byte.
    function automatic seg_item_t peer_seg(logic [7:0] fl, logic [31:0] sq,
                                           logic [3:0] doff, int plen);
        seg_item_t it;
        it.op    = 1'b0;
        it.sport = peer_sport;
        it.dport = listen;
        it.seq   = sq;
        it.ack   = gen_local_seq;
        it.flags = fl;
        it.doff  = doff;
        it.len   = 16'(int'(doff) * 4 + plen);
        it.ip    = peer_ip;
        it.mac   = peer_mac;
        return it;
    endfunction

    // Tell the block the application sent n bytes; other fields are junk.
    task automatic send_note(input int unsigned n);
        seg_item_t it;
        it = noise_item();
        it.op  = 1'b1;
        it.len = 16'(n);
        send_item(it);
        gen_local_seq = gen_local_seq + n;
    endtask

    // Drain everything in flight, then write the listen port.
    task automatic set_listen_port(input logic [15:0] p);
        seg_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let the two-stage pipeline settle before the write
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        listen = p;
    endtask

    // One connection from a fresh peer: SYN, handshake ACK, a mix of data,
    // retransmissions, sends and broken segments, then FIN, RST or nothing.
    task automatic run_session();
        int         steps;
        int         pick;
        int         plen;
        int         back;
        logic [3:0] doff;
        seg_item_t  it;
        peer_sport   = 16'($urandom);
        peer_ip      = $urandom;
        peer_mac     = {16'($urandom), 32'($urandom)};
        gen_peer_seq = $urandom;
        doff         = 4'($urandom_range(15, 5));
        send_item(peer_seg((8'($urandom) & (F_FIN | F_PSH | 8'hE0)) | F_SYN,
                           gen_peer_seq, doff, $urandom_range(8)));
        gen_peer_seq  = gen_peer_seq + 32'd1;
        gen_local_seq = tpr_pkg::LOCAL_ISN + 32'd1;
        if ($urandom_range(9) != 0)
            send_item(peer_seg(F_ACK, gen_peer_seq, 4'd5, 0));
        steps = $urandom_range(24, 2);
        repeat (steps)
        begin
            pick = $urandom_range(99);
            doff = 4'($urandom_range(15, 5));
            // mostly small payloads, now and then up to the field's limit
            plen = ($urandom_range(19) == 0) ? $urandom_range(65535 - 4 * doff)
                                             : $urandom_range(64, 1);
            if (pick < 40)
            begin
                send_item(peer_seg(F_ACK | (8'($urandom) & F_PSH), gen_peer_seq, doff, plen));
                gen_peer_seq = gen_peer_seq + plen;
            end
            else if (pick < 58)
                send_note(($urandom_range(9) == 0) ?
                          $urandom_range(65535) :
                          $urandom_range(tpr_pkg::SEND_MAX_LEN + 2));
            else if (pick < 72)
            begin
                // retransmission: fully seen or overlapping new bytes
                back = $urandom_range(plen + 8, 1);
                send_item(peer_seg(F_ACK, gen_peer_seq - back, doff, plen));
                if (back < plen)
                    gen_peer_seq = gen_peer_seq + (plen - back);
            end
            else if (pick < 78)
                send_item(peer_seg(F_ACK, gen_peer_seq + $urandom_range(4000, 1), doff, plen));
            else if (pick < 84)
            begin
                // header length below the minimum or beyond the segment
                if ($urandom_range(1))
                begin
                    it = peer_seg(F_ACK, gen_peer_seq, 4'($urandom_range(4)), 0);
                    it.len = 16'($urandom_range(100, 20));
                end
                else
                begin
                    doff = 4'($urandom_range(15, 6));
                    it = peer_seg(F_ACK, gen_peer_seq, doff, 0);
                    it.len = 16'($urandom_range(4 * doff - 1, 20));
                end
                send_item(it);
            end
            else if (pick < 90)
            begin
                it = peer_seg(F_ACK, gen_peer_seq, doff, 0);
                if ($urandom_range(1))
                    it.ack = $urandom;
                send_item(it);
            end
            else if (pick < 95)
            begin
                it = peer_seg(F_ACK | F_PSH, gen_peer_seq, doff, plen);
                it.sport = peer_sport ^ 16'($urandom_range(65535, 1));
                send_item(it);
            end
            else
                send_item(noise_item());
        end
        pick = $urandom_range(99);
        if (pick < 30)
            send_item(peer_seg(F_FIN | F_ACK, gen_peer_seq, doff, 0));
        else if (pick < 55)
            send_item(peer_seg(F_FIN | F_ACK | F_PSH, gen_peer_seq, doff, plen));
        else if (pick < 80)
            send_item(peer_seg(F_RST | F_ACK, gen_peer_seq, doff, 0));
    endtask

    initial
    begin
        seg_item_t it;
        int        phase_end;
        rst_n                     <= 1'b0;
        cfg_wr_en                 <= 1'b0;
        cfg_wr_data               <= '0;
        seg_bus.valid             <= 1'b0;
        seg_bus.op                <= 1'b0;
        seg_bus.sender_port       <= '0;
        seg_bus.target_port       <= '0;
        seg_bus.seq               <= '0;
        seg_bus.ack               <= '0;
        seg_bus.flags             <= '0;
        seg_bus.data_offset_words <= '0;
        seg_bus.seg_len           <= '0;
        seg_bus.src_ip            <= '0;
        seg_bus.src_mac           <= '0;
        listen        = '0;
        peer_sport    = '0;
        peer_ip       = '0;
        peer_mac      = '0;
        gen_peer_seq  = '0;
        gen_local_seq = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, top listen port, no idling on either side.
        set_listen_port(16'hFFFF);
        // sends while idle: empty, largest that fits, one too big, field max
        send_note(0);
        send_note(tpr_pkg::SEND_MAX_LEN);
        send_note(tpr_pkg::SEND_MAX_LEN + 1);
        send_note(16'hFFFF);
        gen_local_seq = '0;
        send_item(peer_seg(F_RST, 32'd0, 4'd5, 0));
        // segment shorter than a header
        send_item(peer_seg(F_SYN, 32'd0, 4'd4, 3));
        it = peer_seg(F_SYN, 32'd0, 4'd5, 0);
        it.dport = 16'hFFFE;
        send_item(it);
        // open from an all-ones peer; the sequence wraps to zero
        peer_sport = '1;
        peer_ip    = '1;
        peer_mac   = '1;
        send_item(peer_seg(F_FIN | F_SYN | F_PSH | 8'hE0, 32'hFFFF_FFFF, 4'd15, 65535 - 60));
        gen_local_seq = tpr_pkg::LOCAL_ISN + 32'd1;
        it = peer_seg(F_ACK, 32'd0, 4'd5, 0);
        it.ack = 32'd0;
        send_item(it);
        send_item(peer_seg(F_ACK, 32'd0, 4'd5, 0));
        // bad header lengths
        send_item(peer_seg(F_ACK | F_PSH, 32'd0, 4'd4, 10));
        send_item(peer_seg(F_ACK, 32'd0, 4'd0, 30));
        it = peer_seg(F_ACK, 32'd0, 4'd15, 0);
        it.len = 16'd59;
        send_item(it);
        // in order, duplicate, partly seen, far ahead
        send_item(peer_seg(F_ACK | F_PSH, 32'd0, 4'd5, 100));
        send_item(peer_seg(F_ACK, 32'd0, 4'd5, 100));
        send_item(peer_seg(F_ACK, 32'd50, 4'd5, 80));
        send_item(peer_seg(F_ACK, 32'hFFFF_FFFF, 4'd5, 10));
        it = peer_seg(F_ACK, 32'd130, 4'd5, 10);
        it.sport = 16'h1234;
        send_item(it);
        send_item(peer_seg(F_SYN | F_ACK, 32'd130, 4'd5, 0));
        send_note(10);
        // FIN out of place, then FIN with data, then data after close
        send_item(peer_seg(F_FIN | F_ACK, 32'd129, 4'd5, 0));
        send_item(peer_seg(F_FIN | F_ACK | F_PSH, 32'd130, 4'd5, 5));
        send_item(peer_seg(F_ACK, 32'd136, 4'd5, 8));
        // open from an all-zero peer and close with a bare FIN
        peer_sport = '0;
        peer_ip    = '0;
        peer_mac   = '0;
        send_item(peer_seg(F_SYN, 32'd0, 4'd5, 0));
        gen_local_seq = tpr_pkg::LOCAL_ISN + 32'd1;
        send_item(peer_seg(F_FIN, 32'd1, 4'd5, 0));

        // Random phases: new listen port and idling pattern for each.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_listen_port(16'h0000);
                2: set_listen_port(16'h0050);
                default: set_listen_port(16'($urandom));
            endcase
            idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 11 : 0;
            stall_pct = (ph == 2) ? 67 : (ph == 3) ? 11 : 0;
            phase_end = sent + RANDOM_ITEMS / PHASES;
            while (sent < phase_end)
            begin
                if ($urandom_range(99) < 85)
                    run_session();
                else
                    send_item(noise_item());
            end
        end

        // Drop valid, wait for the last replies, then watch a few more cycles.
        seg_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
